[src/tdpt_pkg.sv]
// ============================================================================
// tdpt_pkg - shared constants for the trial division prime test
// Default operand width used by the top level, remainder unit and checker.
// ============================================================================
package tdpt_pkg;

    // Default width of the tested value (two's complement)
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the output data bus: one flag padded to a byte
    localparam int OUT_DATA_W = 8;

endpackage

[src/tdpt_rem.sv]
// ============================================================================
// tdpt_rem - bit-serial remainder unit
// Restoring division, one dividend bit per cycle; remainder valid with done.
// ============================================================================
module tdpt_rem #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH:0]   trial;

    // Shift in the next dividend bit
    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};

    // One restoring step per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = VALUE_WIDTH'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[VALUE_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[src/trial_division_prime_test.sv]
// Negative, 0..3 and even values are decided in the classify state without the
//   remainder unit; otherwise odd divisors are tried one at a time (3, 5, 7, ...),
//   each through a full run of the bit-serial remainder unit (one dividend bit per cycle).
// Worst case at 32 bits: about 23170 divisors tried.
// One request at a time; the next is taken once the result is in the output register.
// Reset (rst_n low, asynchronous) returns to idle and drops any pending result.
// ============================================================================
// trial_division_prime_test - primality test by trial division
// Sequencer walks odd divisors, tracks d*d incrementally, shares one
// remainder unit for every divisor.
// ============================================================================
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // [VALUE_WIDTH-1:0] candidate
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [tdpt_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // [0] prime_flag
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLASSIFY = 6'b000010,
        S_CHECK    = 6'b000100,
        S_WAIT     = 6'b001000,
        S_STEP     = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic                   flag_reg, flag_next;
    logic                   ovalid_reg, ovalid_next;
    logic                   oflag_reg, oflag_next;
    logic                   rem_start;
    logic                   rem_done;
    logic [VALUE_WIDTH-1:0] rem_val;
    logic [VALUE_WIDTH+1:0] sq_step;
    logic                   in_acc;
    logic                   out_free;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_step = {1'b0, sq_reg} + {div_reg, 2'b00} + (VALUE_WIDTH+2)'(4);

    // Shared remainder unit
    tdpt_rem #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (val_reg),
        .divisor  (div_reg),
        .done     (rem_done),
        .remainder(rem_val)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        div_next    = div_reg;
        sq_next     = sq_reg;
        flag_next   = flag_reg;
        ovalid_next = ovalid_reg;
        oflag_next  = oflag_reg;
        rem_start   = 1'b0;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    val_next   = s_axis_tdata[VALUE_WIDTH-1:0];
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                div_next   = VALUE_WIDTH'(3);
                sq_next    = (VALUE_WIDTH+1)'(9);
                state_next = S_DONE;
                if (val_reg[VALUE_WIDTH-1])
                    flag_next = 1'b0;
                else if (val_reg <= VALUE_WIDTH'(1))
                    flag_next = 1'b0;
                else if (val_reg <= VALUE_WIDTH'(3))
                    flag_next = 1'b1;
                else if (!val_reg[0])
                    flag_next = 1'b0;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // Square past the value: no divisor left
                if (sq_reg > {1'b0, val_reg})
                begin
                    flag_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (rem_done)
                begin
                    if (rem_val == '0)
                    begin
                        flag_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                div_next   = div_reg + VALUE_WIDTH'(2);
                sq_next    = sq_step[VALUE_WIDTH:0];
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oflag_next  = flag_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        flag_reg  <= flag_next;
        oflag_reg <= oflag_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(tdpt_pkg::OUT_DATA_W-1){1'b0}}, oflag_reg};

endmodule

[src/tdpt_checker.sv]
// ============================================================================
// tdpt_checker - port-level assertions for the prime test
// Watches the stream ports of the top level; attached by bind.
// ============================================================================
module tdpt_checker #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tdpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Busy right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // Padding bits of the result are zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[tdpt_pkg::OUT_DATA_W-1:1] == '0)
        else $error("result padding not zero");

    // Negative request taken with the output empty is answered not prime
    a_negative: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[VALUE_WIDTH-1] && !m_axis_tvalid
        |=> ##2 m_axis_tvalid && !m_axis_tdata[0])
        else $error("negative value not reported as not prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tdpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
